/* sv/hsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and the motion pattern table of the hall step
// counter and speed meter.
// ----------------------------------------------------------------------------
package hsc_pkg;

	// Fixed scaling constants of the feedback path.
	localparam int unsigned TicksPerSecond = 32768;
	localparam int unsigned StepsPerRev    = 1380;
	localparam int unsigned RpmScale       = 60000;
	localparam int unsigned AngleScale     = 360;
	localparam int unsigned MsecScale      = 1000;

	// The tick rate is a power of two, so the millisecond rounding is a shift.
	localparam int unsigned TicksShift = $clog2(TicksPerSecond);

	// Angle is steps * 360 / 1380, which reduces to steps * 6 / 23. The divide
	// by 23 is a multiply by ceil(2^37 / 23), split at bit 17, and a shift by 37.
	localparam int unsigned AngleMul     = 6;
	localparam int unsigned AngleRecipHi = 45590;
	localparam int unsigned AngleRecipLo = 34193;

	localparam int unsigned Motors   = 4;
	localparam int unsigned MotorW   = 2;
	localparam int unsigned QueueDepth = 2;

	// Shared divider: 48-bit dividend, 32-bit divisor, one quotient bit a cycle.
	localparam int unsigned DivW     = 48;
	localparam int unsigned DvsW     = 32;
	localparam int unsigned DivCntW  = $clog2(DivW + 1);

	localparam logic [15:0] SamplePeriodReset = 16'd655;

	// Command codes of the request channel.
	localparam logic [1:0] CmdTick   = 2'd0;
	localparam logic [1:0] CmdMotion = 2'd1;

	localparam logic [3:0] MotionLast = 4'd10;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_MOTION,
		KIND_READ
	} hsc_kind_t;

	// One classified request as it travels from the front end to the back end.
	typedef struct packed {
		hsc_kind_t  kind;
		logic [3:0] hall_first;
		logic [3:0] hall_second;
		logic [7:0] pins;
		logic       pins_set;
		logic [1:0] sel;
	} hsc_req_t;

	// Back end status, watched at the top level.
	typedef struct packed {
		logic busy;
		logic div_start;
		logic div_busy;
	} hsc_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MS_MUL,
		ST_MS_ADD,
		ST_MS_SHIFT,
		ST_RPM_MUL,
		ST_RPM_DIV,
		ST_RPM_WAIT,
		ST_ANG_MUL,
		ST_ANG_LO,
		ST_ANG_HI,
		ST_ANG_SIGN,
		ST_DONE
	} hsc_state_t;

	// Drive pin pattern of each mecanum motion code.
	function automatic logic [7:0] motion_pins(input logic [3:0] code);
		logic [7:0] pins;
		case (code)
			4'd0:    pins = 8'h00;
			4'd1:    pins = 8'hAA;
			4'd2:    pins = 8'h55;
			4'd3:    pins = 8'h69;
			4'd4:    pins = 8'h96;
			4'd5:    pins = 8'h28;
			4'd6:    pins = 8'h41;
			4'd7:    pins = 8'h14;
			4'd8:    pins = 8'h82;
			4'd9:    pins = 8'h66;
			4'd10:   pins = 8'h99;
			default: pins = 8'h00;
		endcase
		return pins;
	endfunction

endpackage
`default_nettype wire

/* sv/hsc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_front
// Accepts requests, classifies them and holds them in a two-entry queue
// for the back end.
// ----------------------------------------------------------------------------
module hsc_front
	import hsc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire logic [3:0] hall_first,
	input  wire logic [3:0] hall_second,
	input  wire logic [3:0] motion,
	input  wire logic [1:0] motor_select,
	output logic            req_valid,
	output hsc_req_t        req,
	input  wire logic       req_pop
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	hsc_req_t          mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	hsc_req_t          cls;
	logic              push;

	// Classify the incoming request.
	always_comb begin
		cls.hall_first  = hall_first;
		cls.hall_second = hall_second;
		cls.sel         = motor_select;
		cls.pins        = motion_pins(motion);
		cls.pins_set    = motion inside {[4'd0:MotionLast]};
		case (command)
			CmdTick:   cls.kind = KIND_TICK;
			CmdMotion: cls.kind = KIND_MOTION;
			default:   cls.kind = KIND_READ;
		endcase
	end

	assign in_stall  = (count_q == CntW'(QueueDepth));
	assign push      = in_valid && !in_stall;
	assign req_valid = (count_q != '0);
	assign req       = mem_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (req_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !req_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && req_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

/* sv/hsc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsc_div
	import hsc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [DivW-1:0] dividend,
	input  wire logic [DvsW-1:0] divisor,
	output logic                 busy,
	output logic                 done,
	output logic [DivW-1:0]      quotient
);

	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DvsW-1:0]    rem_q;
	logic [DivW-1:0]    quo_q;
	logic [DvsW-1:0]    dvs_q;
	logic [DvsW:0]      rem_sh;
	logic [DvsW:0]      rem_sub;
	logic               take;

	// One trial subtraction a cycle.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DivW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		take    = (rem_sh >= {1'b0, dvs_q});
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DivCntW'(DivW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DivCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
			quo_q <= {quo_q[DivW-2:0], take};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* sv/hsc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_back
// Executes one request at a time: step counting, speed snapshots through the
// shared divider, angle of the selected motor and the result register.
// ----------------------------------------------------------------------------
module hsc_back
	import hsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] sample_period,
	input  wire logic        req_valid,
	input  hsc_req_t         req,
	output logic             req_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       drive_pins,
	output logic signed [31:0] step_total,
	output logic signed [30:0] angle_degrees,
	output logic signed [31:0] speed_rpm,
	output hsc_stat_t        stat
);

	hsc_state_t        state_q;
	hsc_state_t        state_d;
	hsc_req_t          item_q;
	logic [31:0]       counts_q [Motors];
	logic [31:0]       snap_q   [Motors];
	logic [31:0]       speed_q  [Motors];
	logic [Motors-1:0] last_q;
	logic [15:0]       tick_q;
	logic [7:0]        drive_q;
	logic [MotorW-1:0] mi_q;
	logic              out_valid_q;

	logic [16:0]       elapsed_q;
	logic [DivW-1:0]   prod_q;
	logic [31:0]       ms_q;
	logic              neg_q;
	logic [30:0]       angle_q;
	logic [33:0]       ang_part_q;

	logic [7:0]        out_drive_q;
	logic [31:0]       out_steps_q;
	logic [30:0]       out_angle_q;
	logic [31:0]       out_speed_q;

	logic              div_start;
	logic [DivW-1:0]   div_dividend;
	logic [DvsW-1:0]   div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [DivW-1:0]   div_quo;

	logic              load_out;
	logic [15:0]       elapsed16;
	logic              snap;
	logic [MotorW-1:0] cur_idx;
	logic [31:0]       cur_count;
	logic [31:0]       delta;
	logic              last_motor;
	logic [31:0]       rpm_sat;
	logic [31:0]       steps_mag;
	logic [31:0]       delta_mag;
	logic [50:0]       ang_lo_prod;
	logic [50:0]       ang_sum;

	hsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Snapshot decision, operand selection and saturation.
	always_comb begin
		elapsed16  = tick_q + 16'd1;
		snap       = (elapsed16 >= sample_period) || (elapsed16 == 16'd0);
		cur_idx    = (state_q == ST_RPM_MUL) ? mi_q : item_q.sel;
		cur_count  = counts_q[cur_idx];
		delta      = cur_count - snap_q[mi_q];
		delta_mag  = delta[31] ? (32'd0 - delta) : delta;
		steps_mag  = cur_count[31] ? (32'd0 - cur_count) : cur_count;
		last_motor = (mi_q == MotorW'(Motors - 1));
		if (neg_q) begin
			rpm_sat = (div_quo > DivW'(32'h8000_0000)) ? 32'h8000_0000
				: (32'd0 - div_quo[31:0]);
		end else begin
			rpm_sat = (div_quo > DivW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
				: div_quo[31:0];
		end
		// Partial products of the reciprocal multiply for the angle.
		ang_lo_prod = 51'(prod_q[33:0]) * 51'(AngleRecipLo);
		ang_sum     = 51'(prod_q[33:0]) * 51'(AngleRecipHi) + 51'(ang_part_q);
	end

	// Sequencer next state and control.
	always_comb begin
		state_d      = state_q;
		req_pop      = 1'b0;
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = ms_q;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_pop = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (item_q.kind == KIND_TICK && snap) begin
					state_d = ST_MS_MUL;
				end else begin
					state_d = ST_ANG_MUL;
				end
			end
			ST_MS_MUL:   state_d = ST_MS_ADD;
			ST_MS_ADD:   state_d = ST_MS_SHIFT;
			ST_MS_SHIFT: state_d = ST_RPM_MUL;
			ST_RPM_MUL: begin
				if (ms_q != 32'd0) begin
					state_d = ST_RPM_DIV;
				end else if (last_motor) begin
					state_d = ST_ANG_MUL;
				end
			end
			ST_RPM_DIV: begin
				div_start = 1'b1;
				state_d   = ST_RPM_WAIT;
			end
			ST_RPM_WAIT: begin
				if (div_done) begin
					state_d = last_motor ? ST_ANG_MUL : ST_RPM_MUL;
				end
			end
			ST_ANG_MUL:  state_d = ST_ANG_LO;
			ST_ANG_LO:   state_d = ST_ANG_HI;
			ST_ANG_HI:   state_d = ST_ANG_SIGN;
			ST_ANG_SIGN: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural state: step counts, snapshots, speeds, tick count, drive.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Motors; i++) begin
				counts_q[i] <= '0;
				snap_q[i]   <= '0;
				speed_q[i]  <= '0;
			end
			last_q      <= '0;
			tick_q      <= '0;
			drive_q     <= '0;
			mi_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_EXEC: begin
					if (item_q.kind == KIND_TICK) begin
						// Each motor lane counts an edge of its second hall bit.
						for (int i = 0; i < Motors; i++) begin
							if (item_q.hall_second[i] != last_q[i]) begin
								last_q[i] <= item_q.hall_second[i];
								if (item_q.hall_first[i] == item_q.hall_second[i]) begin
									counts_q[i] <= counts_q[i] + 32'd1;
								end else begin
									counts_q[i] <= counts_q[i] - 32'd1;
								end
							end
						end
						tick_q <= snap ? 16'd0 : elapsed16;
					end else if (item_q.kind == KIND_MOTION && item_q.pins_set) begin
						drive_q <= item_q.pins;
					end
				end
				ST_MS_SHIFT: begin
					mi_q <= '0;
				end
				ST_RPM_MUL: begin
					snap_q[mi_q] <= cur_count;
					if (ms_q == 32'd0) begin
						speed_q[mi_q] <= 32'd0;
						mi_q          <= mi_q + 1'b1;
					end
				end
				ST_RPM_WAIT: begin
					if (div_done) begin
						speed_q[mi_q] <= rpm_sat;
						mi_q          <= mi_q + 1'b1;
					end
				end
				default: begin
				end
			endcase

			// Result register: a new result loads, a taken one clears.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the result payload.
	always_ff @(posedge clk) begin
		if (req_pop) begin
			item_q <= req;
		end
		case (state_q)
			ST_EXEC: begin
				elapsed_q <= (elapsed16 == 16'd0) ? 17'h1_0000 : {1'b0, elapsed16};
			end
			ST_MS_MUL: begin
				prod_q <= DivW'(elapsed_q) * DivW'(StepsPerRev);
			end
			ST_MS_ADD: begin
				prod_q <= prod_q * DivW'(MsecScale) + DivW'(TicksPerSecond / 2);
			end
			ST_MS_SHIFT: begin
				// Rounded milliseconds times steps per revolution: the tick rate divides as a shift.
				ms_q <= 32'(prod_q >> TicksShift);
			end
			ST_RPM_MUL: begin
				neg_q  <= delta[31];
				prod_q <= DivW'(delta_mag) * DivW'(RpmScale);
			end
			ST_ANG_MUL: begin
				neg_q  <= cur_count[31];
				prod_q <= DivW'(steps_mag) * DivW'(AngleMul);
			end
			ST_ANG_LO: begin
				ang_part_q <= ang_lo_prod[50:17];
			end
			ST_ANG_HI: begin
				// Quotient by 23 is the full product shifted right by 37.
				angle_q <= ang_sum[50:20];
			end
			ST_ANG_SIGN: begin
				if (neg_q) begin
					angle_q <= 31'd0 - angle_q;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_drive_q <= drive_q;
			out_steps_q <= cur_count;
			out_angle_q <= angle_q;
			out_speed_q <= speed_q[item_q.sel];
		end
	end

	assign out_valid     = out_valid_q;
	assign drive_pins    = out_drive_q;
	assign step_total    = out_steps_q;
	assign angle_degrees = out_angle_q;
	assign speed_rpm     = out_speed_q;

	assign stat.busy      = (state_q != ST_IDLE);
	assign stat.div_start = div_start;
	assign stat.div_busy  = div_busy;

endmodule
`default_nettype wire

/* sv/hall_step_counter_speed_meter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hall_step_counter_speed_meter
// Four-motor hall step counter with periodic rpm snapshots, angle readout
// and mecanum drive pin patterns.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  request  | in_valid / in_stall       | command, hall_first, hall_second,
//           |                           | motion, motor_select
//  result   | out_valid / out_stall     | drive_pins, step_total,
//           |                           | angle_degrees, speed_rpm
//  config   | cfg_write_en              | cfg_write_data (sample_period)
//
// A request runs from the queue through the reciprocal multiply for the angle
// (multiply, low and high partial products, sign) to its result; a tick that
// takes a speed snapshot adds one divider pass per motor. Reset clears all
// counts, speeds and drive_q, but not the result outputs; sample_period
// returns to 655. A two-entry queue takes requests while the back end works,
// and the result register holds a finished result while out_stall is high.
module hall_step_counter_speed_meter
	import hsc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [15:0] cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [3:0]  hall_first,
	input  wire logic [3:0]  hall_second,
	input  wire logic [3:0]  motion,
	input  wire logic [1:0]  motor_select,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       drive_pins,
	output logic signed [31:0] step_total,
	output logic signed [30:0] angle_degrees,
	output logic signed [31:0] speed_rpm
);

	logic [15:0] sample_period_q;
	logic        req_valid;
	logic        req_pop;
	hsc_req_t    req;
	hsc_stat_t   stat;

	// Sample period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_period_q <= SamplePeriodReset;
		end else if (cfg_write_en) begin
			sample_period_q <= cfg_write_data;
		end
	end

	hsc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.hall_first   (hall_first),
		.hall_second  (hall_second),
		.motion       (motion),
		.motor_select (motor_select),
		.req_valid    (req_valid),
		.req          (req),
		.req_pop      (req_pop)
	);

	hsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_period (sample_period_q),
		.req_valid     (req_valid),
		.req           (req),
		.req_pop       (req_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.drive_pins    (drive_pins),
		.step_total    (step_total),
		.angle_degrees (angle_degrees),
		.speed_rpm     (speed_rpm),
		.stat          (stat)
	);

	// The back end only takes a request that the queue holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> req_valid)
		else $error("request taken from an empty queue");

	// The shared divider is never restarted while it iterates.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_start |-> !stat.div_busy)
		else $error("divider started while busy");

	// A result appears only at the end of a request's execution.
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(stat.busy))
		else $error("result without an executing request");

endmodule
`default_nettype wire
